// File: design/apfc_pkg.sv
// ----------------------------------------------------------------------------
// apfc_pkg
// Shared types and saturation helper for the allpass filter chain.
// ----------------------------------------------------------------------------
package apfc_pkg;

    // Section state and in-chain sample width
    localparam int STATE_BITS = 32;
    // Rounded k*v term: coefficient (frac+2 bits) times state, less frac bits
    localparam int RND_BITS   = STATE_BITS + 2;
    // Sum of a state-width word and a rounded product term
    localparam int SUM_BITS   = RND_BITS + 1;

    typedef logic signed [STATE_BITS-1:0] t_state;
    typedef logic signed [RND_BITS-1:0]   t_rnd;
    typedef logic signed [SUM_BITS-1:0]   t_sum;

    // Word handed from one section to the next
    typedef struct packed {
        logic   valid;
        t_state data;
    } t_link;

    // Clamp a widened sum to the signed state range
    function automatic t_state sat_state(input t_sum v);
        logic [SUM_BITS-STATE_BITS:0] head;
        t_state                       res;
        head = v[SUM_BITS-1:STATE_BITS-1];
        if ((&head) || !(|head)) begin
            res = v[STATE_BITS-1:0];
        end else if (v[SUM_BITS-1]) begin
            res = {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// File: design/apfc_cell.sv
// ----------------------------------------------------------------------------
// apfc_cell
// One first-order allpass section: holds its state word, forms and registers u,
// then forms and registers y from it and hands y to the next section.
// ----------------------------------------------------------------------------
module apfc_cell #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [COEF_FRAC_BITS+1:0] i_coef,
    input  apfc_pkg::t_link                 i_link,
    output apfc_pkg::t_link                 o_link
);
    import apfc_pkg::*;

    localparam int PROD_BITS = COEF_FRAC_BITS + 2 + STATE_BITS;
    localparam logic signed [PROD_BITS-1:0] C_RND =
        {{(PROD_BITS-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

    t_state r_state;
    t_state r_u;
    t_state r_s_old;
    logic   r_u_valid;
    t_state r_y;
    logic   r_y_valid;

    logic signed [PROD_BITS-1:0] w_p1;
    logic signed [PROD_BITS-1:0] w_p2;
    t_rnd                        w_q1;
    t_rnd                        w_q2;
    t_state                      n_u;
    t_state                      n_y;

    // First half: u = x + round(k*s)
    assign w_p1 = PROD_BITS'(i_coef) * PROD_BITS'(r_state);
    assign w_q1 = t_rnd'((w_p1 + C_RND) >>> COEF_FRAC_BITS);
    assign n_u  = sat_state(t_sum'(i_link.data) + t_sum'(w_q1));

    // Second half: y = s - round(k*u)
    assign w_p2 = PROD_BITS'(i_coef) * PROD_BITS'(r_u);
    assign w_q2 = t_rnd'((w_p2 + C_RND) >>> COEF_FRAC_BITS);
    assign n_y  = sat_state(t_sum'(r_s_old) - t_sum'(w_q2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_u_valid <= 1'b0;
            r_y_valid <= 1'b0;
        end else begin
            r_u_valid <= i_link.valid;
            r_y_valid <= r_u_valid;
            if (i_link.valid) begin
                r_state <= n_u;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_link.valid) begin
            r_u     <= n_u;
            r_s_old <= r_state;
        end
        if (r_u_valid) begin
            r_y <= n_y;
        end
    end

    assign o_link.valid = r_y_valid;
    assign o_link.data  = r_y;

endmodule

// File: design/allpass_filter_chain_unit.sv
// ----------------------------------------------------------------------------
// allpass_filter_chain_unit
// Path: each section registers u, then y (one multiply each); the last y goes
//   to the holding register, then to the output register. One word is in the
//   chain at a time; the next is taken once the result leaves the holding register.
// Reset (synchronous, active low): all section states to zero, coefficient to
//   49655, chain and output empty, input ready held low until reset is released.
// ----------------------------------------------------------------------------
// Cascade of first-order allpass sections sharing one Q1.x coefficient.
// Per section: u = sat32(x + round(k*s)), y = sat32(s - round(k*u)), s <= u.
// The word walks along a row of apfc_cell instances; each cell keeps its own
// state word and passes y to its neighbour. The last y is clamped to the
// sample width, parked in a holding register and moved to the output register
// as soon as that is free, so a new word can be taken while the previous
// result still waits downstream.
// ----------------------------------------------------------------------------
module allpass_filter_chain_unit #(
    parameter int STAGE_COUNT    = 16,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic signed [COEF_FRAC_BITS+1:0] i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample_in,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]    o_sample_out
);
    import apfc_pkg::*;

    localparam int COEF_BITS = COEF_FRAC_BITS + 2;
    localparam logic signed [COEF_BITS-1:0] C_COEF_RESET = COEF_BITS'(49655);
    localparam t_state C_SMAX = t_state'(32'sh7FFF_FFFF >>> (STATE_BITS - SAMPLE_BITS));
    localparam t_state C_SMIN = ~C_SMAX;

    logic signed [COEF_BITS-1:0]   r_allpass_coefficient;
    logic                          r_busy;
    logic                          r_pend_valid;
    logic signed [SAMPLE_BITS-1:0] r_pend_sample;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;

    t_link                         w_link [STAGE_COUNT+1];
    logic                          w_accept;
    logic                          w_move;
    t_state                        w_last;
    t_state                        n_clamped;

    // Take no word while reset is held
    assign o_in_ready = i_rst_n && !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    // Move the held result on when the output register is empty or draining
    assign w_move     = r_pend_valid && (!r_out_valid || i_out_ready);

    // Feed the first section straight from the port on accept
    assign w_link[0].valid = w_accept;
    assign w_link[0].data  = t_state'(i_sample_in);

    for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_cell
        apfc_cell #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (r_allpass_coefficient),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    // Clamp the last section's output to the sample range
    assign w_last = w_link[STAGE_COUNT].data;
    always_comb begin
        if (w_last > C_SMAX) begin
            n_clamped = C_SMAX;
        end else if (w_last < C_SMIN) begin
            n_clamped = C_SMIN;
        end else begin
            n_clamped = w_last;
        end
    end

    // Control: coefficient, occupancy, holding and output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allpass_coefficient <= C_COEF_RESET;
            r_busy                <= 1'b0;
            r_pend_valid          <= 1'b0;
            r_out_valid           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_allpass_coefficient <= i_cfg_data;
            end
            // Hold busy from accept until the result leaves the holding register
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_link[STAGE_COUNT].valid) begin
                r_pend_valid <= 1'b1;
            end else if (w_move) begin
                r_pend_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_link[STAGE_COUNT].valid) begin
            r_pend_sample <= SAMPLE_BITS'(n_clamped);
        end
        if (w_move) begin
            r_out_sample <= r_pend_sample;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;

endmodule

// File: design/apfc_checker.sv
// ----------------------------------------------------------------------------
// apfc_checker
// Port-level checks for the allpass filter chain, bound to the top level.
// ----------------------------------------------------------------------------
module apfc_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    // One word in the chain at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is in the chain");

    // Ready only drops because a word was taken
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid))
        else $error("input ready dropped without an accept");

    // A fresh result frees the chain for the next word
    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result shown while the chain is still busy");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_sample_out)))
        else $error("stalled output word changed or vanished");

endmodule

bind allpass_filter_chain_unit apfc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_apfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out)
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cascaded allpass filter chain.
// Every accepted input word runs through a bit-accurate predictor of the
// sixteen sections. Each output word is compared with the oldest prediction.
// Idling and stalls vary over the run, and the run covers the coefficient
// rails, unity, zero and random values.
// ----------------------------------------------------------------------------
module tb_top;
    import apfc_pkg::*;

    localparam int STAGES      = 16;
    localparam int SAMPLE_W    = 24;
    localparam int FRAC_W      = 16;
    localparam int COEF_W      = FRAC_W + 2;
    localparam int COEF_RESET  = 49655;
    localparam int COEF_ONE    = 1 << FRAC_W;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 200;
    localparam int MODE_RUN    = 50;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 2 * STAGES + 8;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam t_coef   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam t_coef   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the coefficient and section states, predicts
    // each output word when its input is accepted and queues it in order.
    // ------------------------------------------------------------------------
    class allpass_scoreboard;
        t_coef       coef;
        t_state      section_u [STAGES];
        t_sample     expected_samples [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned accepted;

        function new();
            coef = t_coef'(COEF_RESET);
            foreach (section_u[i]) section_u[i] = '0;
            mismatches = 0;
            checked    = 0;
            accepted   = 0;
        endfunction

        function longint saturate(longint v, int w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // k*v rounded half up back to the sample scale (arithmetic shift floors)
        function longint coef_product(longint v);
            longint k;
            longint p;
            k = coef;
            p = k * v;
            return (p + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        endfunction

        function t_sample filter_sample(t_sample smp);
            longint x;
            longint s;
            longint u;
            x = smp;
            for (int i = 0; i < STAGES; i++) begin
                s = section_u[i];
                u = saturate(x + coef_product(s), STATE_BITS);
                x = saturate(s - coef_product(u), STATE_BITS);
                section_u[i] = t_state'(u);
            end
            return t_sample'(saturate(x, SAMPLE_W));
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task note_input(t_sample smp);
            accepted++;
            expected_samples.push_back(filter_sample(smp));
        endtask

        task check_result(t_sample got);
            t_sample want;
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("sample_out %0d with no word pending", got));
                return;
            end
            want = expected_samples.pop_front();
            checked++;
            if (got !== want)
                report_mismatch($sformatf("sample_out %0d, predicted %0d", got, want));
        endtask

        task check_drained();
            if (expected_samples.size() != 0)
                report_mismatch($sformatf("%0d predicted words never came out",
                                          expected_samples.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Stimulus signals, all known from time zero
    // ------------------------------------------------------------------------
    logic    i_clk     = 1'b0;
    logic    i_rst_n   = 1'b0;
    logic    cfg_we    = 1'b0;
    t_coef   cfg_data  = '0;
    logic    in_valid  = 1'b0;
    logic    in_ready;
    t_sample sample_in = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    t_sample sample_out;

    int unsigned gap_pct         = 0;
    int unsigned stall_pct       = 0;
    logic        hold_off        = 1'b0;
    logic        pressure_req    = 1'b0;
    int unsigned cycle_count     = 0;
    int unsigned in_stall_cycles = 0;
    int unsigned coef_writes     = 0;

    allpass_scoreboard apf_sb;

    allpass_filter_chain_unit #(
        .STAGE_COUNT    (STAGES),
        .SAMPLE_BITS    (SAMPLE_W),
        .COEF_FRAC_BITS (FRAC_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_sample_in  (sample_in),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_sample_out (sample_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: stop a hung run long after the slowest correct one would end
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("watchdog: run exceeded %0d cycles", CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Monitor: all drives are nonblocking, so these reads see pre-edge values,
    // i.e. exactly what the block saw at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) apf_sb.note_input(sample_in);
            if (in_valid && !in_ready) in_stall_cycles++;
            if (out_valid && out_ready) apf_sb.check_result(sample_out);
        end
    end

    // Receiver: drop ready at random, or hold it low outright during a squeeze
    always @(posedge i_clk) begin
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Squeeze: hold off the receiver for a long stretch so the chain and its
    // output registers fill up and the input side has to stall
    initial begin
        forever begin
            wait (pressure_req);
            pressure_req = 1'b0;
            @(posedge i_clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    task automatic set_idle_mode(t_idle_mode m);
        case (m)
            IDLE_NONE: begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                gap_pct   = 54;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                gap_pct   = 0;
                stall_pct = 54;
            end
            default: begin
                gap_pct   = 10;
                stall_pct = 10;
            end
        endcase
    endtask

    // Offer one word after a random gap; hold it steady until it is taken.
    // Valid is only ever assigned once per edge.
    task automatic send_word(t_sample smp);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        sample_in <= smp;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
    endtask

    // Stop offering and wait until every predicted word has come out.
    // The extra edge lets the monitor note a word taken at the current edge.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (apf_sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write the coefficient only with the chain empty
    task automatic write_coefficient(t_coef k);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= k;
        @(posedge i_clk);
        apf_sb.coef = k;
        cfg_we <= 1'b0;
        coef_writes++;
    endtask

    initial begin
        t_sample     warmup_words [12];
        t_sample     rail_words [5];
        t_coef       coef_plan [PHASES];
        t_sample     smp;
        int unsigned pick;

        apf_sb = new();

        rail_words   = '{SAMPLE_MAX, SAMPLE_MIN, t_sample'(0), t_sample'(-1), t_sample'(1)};
        // Impulse and step edges at the reset coefficient, then the rails
        warmup_words = '{SAMPLE_MAX, t_sample'(0), t_sample'(0), t_sample'(0),
                         SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, t_sample'(1),
                         t_sample'(-1), t_sample'(0), t_sample'(4194304),
                         t_sample'(-4194305)};
        coef_plan = '{t_coef'(COEF_RESET), t_coef'(COEF_ONE), t_coef'(0),
                      t_coef'(-COEF_ONE),
                      t_coef'(int'($urandom_range(2 * COEF_ONE)) - COEF_ONE),
                      COEF_MAX, t_coef'($urandom()), COEF_MIN};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset coefficient first, untouched by any write
        set_idle_mode(IDLE_NONE);
        foreach (warmup_words[i]) send_word(warmup_words[i]);

        // Gain near +2: states run away and clamp at 32 bits, output clamps too
        write_coefficient(COEF_MAX);
        repeat (6) send_word(SAMPLE_MAX);

        // Gain of -2 with alternating rails: clamp in the other direction
        write_coefficient(COEF_MIN);
        for (int i = 0; i < 6; i++) send_word((i % 2 == 1) ? SAMPLE_MAX : SAMPLE_MIN);

        // Random part: one coefficient per phase, idling mode rotates every
        // few dozen words so gaps land on every cycle of a word's pass
        for (int p = 0; p < PHASES; p++) begin
            write_coefficient(coef_plan[p]);
            if (p == 2 || p == 5) pressure_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % MODE_RUN == 0)
                    set_idle_mode(t_idle_mode'((p + n / MODE_RUN) % 4));
                pick = $urandom_range(99);
                if (pick < 60) begin
                    smp = t_sample'($urandom());
                end else if (pick < 75) begin
                    smp = rail_words[$urandom_range(4)];
                end else begin
                    smp = t_sample'(int'($urandom_range(512)) - 256);
                end
                send_word(smp);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        apf_sb.check_drained();

        $display("covered %0d input words over %0d coefficient writes (reset value,",
                 apf_sb.accepted, coef_writes);
        $display("unity both signs, zero, 18-bit rails, random); %0d outputs compared,",
                 apf_sb.checked);
        $display("%0d cycles of input back-pressure", in_stall_cycles);
        if (apf_sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/apfc_pkg.sv
design/apfc_cell.sv
design/allpass_filter_chain_unit.sv
design/apfc_checker.sv
dv/tb_top.sv
